@@ hdl/ddpi_pkg.sv @@
// ----------------------------------------------------------------------------
// ddpi_pkg: shared types and constants of the pose integrator
// Widths of the shared arithmetic units, the CORDIC arctangent table,
// the sequencer states and the register map.
// ----------------------------------------------------------------------------
package ddpi_pkg;

  localparam int CORDIC_STEPS = 28;
  localparam int CORDIC_CW    = 5;
  localparam int ANG_W        = 34;   // CORDIC datapath, Q2.30 plus headroom
  localparam int MUL_AW       = 40;
  localparam int MUL_BW       = 34;
  localparam int MUL_PW       = MUL_AW + MUL_BW;
  localparam int DIV_NW       = 58;
  localparam int DIV_DW       = 38;
  localparam int DELTA_W      = 60;

  localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [21:0] TURN_PER_RAD_Q24 = 22'd2670177;

  localparam logic [15:0] TIME_STEP_RESET      = 16'd6554;
  localparam logic [15:0] STRAIGHT_LIMIT_RESET = 16'd1;

  localparam logic REG_TIME_STEP      = 1'b0;
  localparam logic REG_STRAIGHT_LIMIT = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROT0,
    S_MUL_SPD,
    S_MUL_X,
    S_MUL_Y,
    S_MUL_TURN,
    S_ROT1,
    S_MUL_NX,
    S_DIV_X,
    S_MUL_NY,
    S_DIV_Y,
    S_UPD
  } seq_state_t;

  function automatic logic [29:0] atan_at(input logic [CORDIC_CW-1:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0:    r = 30'h20000000;
      5'd1:    r = 30'h12E4051E;
      5'd2:    r = 30'h09FB385B;
      5'd3:    r = 30'h051111D4;
      5'd4:    r = 30'h028B0D43;
      5'd5:    r = 30'h0145D7E1;
      5'd6:    r = 30'h00A2F61E;
      5'd7:    r = 30'h00517C55;
      5'd8:    r = 30'h0028BE53;
      5'd9:    r = 30'h00145F2F;
      5'd10:   r = 30'h000A2F98;
      5'd11:   r = 30'h000517CC;
      5'd12:   r = 30'h00028BE6;
      5'd13:   r = 30'h000145F3;
      5'd14:   r = 30'h0000A2FA;
      5'd15:   r = 30'h0000517D;
      5'd16:   r = 30'h000028BE;
      5'd17:   r = 30'h0000145F;
      5'd18:   r = 30'h00000A30;
      5'd19:   r = 30'h00000518;
      5'd20:   r = 30'h0000028C;
      5'd21:   r = 30'h00000146;
      5'd22:   r = 30'h000000A3;
      5'd23:   r = 30'h00000051;
      5'd24:   r = 30'h00000029;
      5'd25:   r = 30'h00000014;
      5'd26:   r = 30'h0000000A;
      5'd27:   r = 30'h00000005;
      default: r = 30'h0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/ddpi_cordic.sv @@
// ----------------------------------------------------------------------------
// ddpi_cordic: iterative rotation CORDIC
// Cosine and sine of a 32-bit binary angle, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module ddpi_cordic
  import ddpi_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [31:0]             angle,
  output unit_stat_t              stat,
  output logic signed [ANG_W-1:0] cos_o,
  output logic signed [ANG_W-1:0] sin_o
);

  logic signed [ANG_W-1:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic signed [ANG_W-1:0] cos_r, sin_r;
  logic [1:0]              q_r;
  logic [CORDIC_CW-1:0]    cnt_r;
  logic                    busy_r, done_r;
  logic [31:0]             qa, rr;
  logic [1:0]              q0;
  logic signed [ANG_W-1:0] at, sx, sy;

  always_comb begin
    qa = angle + 32'h2000_0000;
    q0 = qa[31:30];
    rr = angle - {q0, 30'b0};
    at = {{(ANG_W-30){1'b0}}, atan_at(cnt_r)};
    sx = y_r >>> cnt_r;
    sy = x_r >>> cnt_r;
    if (!z_r[ANG_W-1]) begin
      x_nxt = x_r - sx;
      y_nxt = y_r + sy;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + sx;
      y_nxt = y_r - sy;
      z_nxt = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CORDIC_CW'(CORDIC_STEPS - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CORDIC_CW'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= CORDIC_GAIN;
      y_r <= '0;
      z_r <= {{(ANG_W-32){rr[31]}}, rr};
      q_r <= q0;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      if (cnt_r == CORDIC_CW'(CORDIC_STEPS - 1)) begin
        case (q_r)
          2'd0: begin cos_r <= x_nxt;  sin_r <= y_nxt;  end
          2'd1: begin cos_r <= -y_nxt; sin_r <= x_nxt;  end
          2'd2: begin cos_r <= -x_nxt; sin_r <= -y_nxt; end
          default: begin cos_r <= y_nxt; sin_r <= -x_nxt; end
        endcase
      end
    end
  end

  assign stat  = '{busy: busy_r, done: done_r};
  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

@@ hdl/ddpi_mul.sv @@
// ----------------------------------------------------------------------------
// ddpi_mul: shift-add multiplier
// Unsigned product, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ddpi_mul
  import ddpi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MUL_AW-1:0] a,
  input  logic [MUL_BW-1:0] b,
  output unit_stat_t        stat,
  output logic [MUL_PW-1:0] prod
);

  localparam int CW = $clog2(MUL_BW);

  logic [MUL_PW-1:0] acc_r, a_r;
  logic [MUL_BW-1:0] b_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CW'(MUL_BW - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(MUL_BW - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= {{MUL_BW{1'b0}}, a};
      b_r   <= b;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

  assign stat = '{busy: busy_r, done: done_r};
  assign prod = acc_r;

endmodule

@@ hdl/ddpi_div.sv @@
// ----------------------------------------------------------------------------
// ddpi_div: restoring divider
// Unsigned quotient, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ddpi_div
  import ddpi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] n,
  input  logic [DIV_DW-1:0] d,
  output unit_stat_t        stat,
  output logic [DIV_NW-1:0] quo
);

  localparam int CW = $clog2(DIV_NW);

  logic [DIV_NW-1:0] q_r;
  logic [DIV_DW-1:0] d_r, rem_r;
  logic [DIV_DW:0]   trial;
  logic              fits;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, done_r;

  always_comb begin
    trial = {rem_r, q_r[DIV_NW-1]};
    fits  = trial >= {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CW'(DIV_NW - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_NW - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= n;
      d_r   <= d;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? DIV_DW'(trial - {1'b0, d_r}) : trial[DIV_DW-1:0];
      q_r   <= {q_r[DIV_NW-2:0], fits};
    end
  end

  assign stat = '{busy: busy_r, done: done_r};
  assign quo  = q_r;

endmodule

@@ hdl/differential_drive_pose_integrator.sv @@
// ----------------------------------------------------------------------------
// differential_drive_pose_integrator: fixed-point unicycle odometry
// Advances a planar pose by one time step per speed command word.
// ----------------------------------------------------------------------------
// One command word is worked on at a time; in_stall is high from acceptance
// until the pose has been updated. Three shared units do the arithmetic under
// a small sequencer: a CORDIC, a shift-add multiplier and a restoring divider.
// A straight step takes one CORDIC pass and three products; an arc step takes
// two CORDIC passes, four products and two divisions. The result word sits in
// the output registers until taken, and the next command is accepted
// meanwhile; its pose update waits only if that word is still held at the end
// of its computation.
module differential_drive_pose_integrator
  import ddpi_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_linear_speed,
  input  logic signed [23:0] in_angular_speed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [15:0]        out_heading,
  output logic               out_saturated,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Configuration registers.
  logic [15:0] time_step_r, straight_limit_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_STRAIGHT_LIMIT) ? {16'b0, straight_limit_r}
                                                   : {16'b0, time_step_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r      <= TIME_STEP_RESET;
      straight_limit_r <= STRAIGHT_LIMIT_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_TIME_STEP:      time_step_r      <= pwdata[15:0];
        REG_STRAIGHT_LIMIT: straight_limit_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath state.
  seq_state_t state_r, state_nxt;
  logic       kick_r;
  logic       out_valid_r, sat_r;
  logic signed [31:0] x_r, y_r;
  logic [15:0] yaw_r;

  logic        v_neg_r, w_neg_r, straight_r;
  logic [23:0] v_mag_r, w_mag_r;
  logic signed [ANG_W-1:0] c0_r, s0_r, c1_r, s1_r;
  logic [MUL_AW-1:0] spd_mag_r;
  logic [31:0] a1_r;
  logic signed [DELTA_W-1:0] ddx_r, ddy_r;

  // Shared units.
  unit_stat_t cor_stat, mul_stat, div_stat;
  logic cor_start, mul_start, div_start;
  logic [31:0] cor_angle;
  logic signed [ANG_W-1:0] cor_cos, cor_sin;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] mul_prod;
  logic [DIV_NW-1:0] div_n, div_q;
  logic [DIV_DW-1:0] div_d;

  ddpi_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cor_start), .angle(cor_angle),
    .stat(cor_stat), .cos_o(cor_cos), .sin_o(cor_sin)
  );

  ddpi_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .stat(mul_stat), .prod(mul_prod)
  );

  ddpi_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .n(div_n), .d(div_d),
    .stat(div_stat), .quo(div_q)
  );

  // Operand preparation.
  logic in_acc, upd_go;
  logic [23:0] in_v_mag, in_w_mag;
  logic [ANG_W-1:0] c0_mag, s0_mag;
  logic [25:0] c22_mag, s22_mag;
  logic signed [ANG_W:0] dsx, dcy;
  logic [ANG_W:0] dsx_mag, dcy_mag;
  logic [MUL_PW-1:0] rnd38, rnd24;
  logic [DELTA_W-1:0] str_mag, arc_mag;
  logic [31:0] d_mag32, d32, a1_rnd;

  assign in_acc = in_valid && !in_stall;
  assign upd_go = !out_valid_r || !out_stall;

  always_comb begin
    in_v_mag = in_linear_speed[23] ? 24'(-in_linear_speed) : in_linear_speed;
    in_w_mag = in_angular_speed[23] ? 24'(-in_angular_speed) : in_angular_speed;
    c0_mag   = c0_r[ANG_W-1] ? ANG_W'(-c0_r) : c0_r;
    s0_mag   = s0_r[ANG_W-1] ? ANG_W'(-s0_r) : s0_r;
    c22_mag  = 26'((c0_mag + ANG_W'(128)) >> 8);
    s22_mag  = 26'((s0_mag + ANG_W'(128)) >> 8);
    dsx      = (ANG_W+1)'(s1_r) - (ANG_W+1)'(s0_r);
    dcy      = (ANG_W+1)'(c0_r) - (ANG_W+1)'(c1_r);
    dsx_mag  = dsx[ANG_W] ? (ANG_W+1)'(-dsx) : dsx;
    dcy_mag  = dcy[ANG_W] ? (ANG_W+1)'(-dcy) : dcy;
    rnd38    = mul_prod + (MUL_PW'(1) << 37);
    rnd24    = mul_prod + (MUL_PW'(1) << 23);
    str_mag  = {{(DELTA_W-36){1'b0}}, rnd38[MUL_PW-1:38]};
    arc_mag  = {{(DELTA_W-DIV_NW){1'b0}}, div_q};
    d_mag32  = rnd24[55:24];
    d32      = w_neg_r ? 32'(-d_mag32) : d_mag32;
    a1_rnd   = a1_r + 32'h0000_8000;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_acc) state_nxt = S_ROT0;
      S_ROT0:     if (cor_stat.done) state_nxt = S_MUL_SPD;
      S_MUL_SPD:  if (mul_stat.done) state_nxt = straight_r ? S_MUL_X : S_MUL_TURN;
      S_MUL_X:    if (mul_stat.done) state_nxt = S_MUL_Y;
      S_MUL_Y:    if (mul_stat.done) state_nxt = S_UPD;
      S_MUL_TURN: if (mul_stat.done) state_nxt = S_ROT1;
      S_ROT1:     if (cor_stat.done) state_nxt = S_MUL_NX;
      S_MUL_NX:   if (mul_stat.done) state_nxt = S_DIV_X;
      S_DIV_X:    if (div_stat.done) state_nxt = S_MUL_NY;
      S_MUL_NY:   if (mul_stat.done) state_nxt = S_DIV_Y;
      S_DIV_Y:    if (div_stat.done) state_nxt = S_UPD;
      S_UPD:      if (upd_go) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Unit control: each unit is kicked on the first cycle of its state.
  always_comb begin
    cor_start = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    cor_angle = {yaw_r, 16'h0};
    mul_a     = spd_mag_r;
    mul_b     = '0;
    div_n     = mul_prod[DIV_NW-1:0] + {21'b0, w_mag_r, 13'b0};
    div_d     = {w_mag_r, 14'b0};
    case (state_r)
      S_ROT0: cor_start = kick_r;
      S_MUL_SPD: begin
        mul_start = kick_r;
        mul_a     = {16'b0, straight_r ? v_mag_r : w_mag_r};
        mul_b     = {18'b0, time_step_r};
      end
      S_MUL_X: begin
        mul_start = kick_r;
        mul_b     = {8'b0, c22_mag};
      end
      S_MUL_Y: begin
        mul_start = kick_r;
        mul_b     = {8'b0, s22_mag};
      end
      S_MUL_TURN: begin
        mul_start = kick_r;
        mul_b     = {12'b0, TURN_PER_RAD_Q24};
      end
      S_ROT1: begin
        cor_start = kick_r;
        cor_angle = a1_r;
      end
      S_MUL_NX: begin
        mul_start = kick_r;
        mul_a     = {16'b0, v_mag_r};
        mul_b     = dsx_mag[MUL_BW-1:0];
      end
      S_MUL_NY: begin
        mul_start = kick_r;
        mul_a     = {16'b0, v_mag_r};
        mul_b     = dcy_mag[MUL_BW-1:0];
      end
      S_DIV_X: div_start = kick_r;
      S_DIV_Y: div_start = kick_r;
      default: ;
    endcase
  end

  // Position update with saturation to the Q15.16 range.
  localparam logic signed [DELTA_W:0] POS_MAX = 61'sd2147483647;
  localparam logic signed [DELTA_W:0] POS_MIN = -61'sd2147483648;
  logic signed [DELTA_W:0] sum_x, sum_y;
  logic signed [31:0] x_nxt, y_nxt;
  logic sat_x, sat_y;

  always_comb begin
    sum_x = (DELTA_W+1)'(x_r) + (DELTA_W+1)'(ddx_r);
    sum_y = (DELTA_W+1)'(y_r) + (DELTA_W+1)'(ddy_r);
    sat_x = (sum_x > POS_MAX) || (sum_x < POS_MIN);
    sat_y = (sum_y > POS_MAX) || (sum_y < POS_MIN);
    x_nxt = sat_x ? (sum_x[DELTA_W] ? 32'sh8000_0000 : 32'sh7fff_ffff) : sum_x[31:0];
    y_nxt = sat_y ? (sum_y[DELTA_W] ? 32'sh8000_0000 : 32'sh7fff_ffff) : sum_y[31:0];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kick_r      <= 1'b0;
      out_valid_r <= 1'b0;
      sat_r       <= 1'b0;
      x_r         <= '0;
      y_r         <= '0;
      yaw_r       <= '0;
    end else begin
      state_r <= state_nxt;
      kick_r  <= state_nxt != state_r;
      if (state_r == S_UPD && upd_go) begin
        out_valid_r <= 1'b1;
        sat_r       <= sat_x || sat_y;
        x_r         <= x_nxt;
        y_r         <= y_nxt;
        if (!straight_r) begin
          yaw_r <= a1_rnd[31:16];
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      v_neg_r    <= in_linear_speed[23];
      w_neg_r    <= in_angular_speed[23];
      v_mag_r    <= in_v_mag;
      w_mag_r    <= in_w_mag;
      straight_r <= (in_angular_speed == 24'sd0) || (in_w_mag < {8'b0, straight_limit_r});
    end
    case (state_r)
      S_ROT0: if (cor_stat.done) begin
        c0_r <= cor_cos;
        s0_r <= cor_sin;
      end
      S_MUL_SPD: if (mul_stat.done) spd_mag_r <= mul_prod[MUL_AW-1:0];
      S_MUL_X: if (mul_stat.done)
        ddx_r <= (v_neg_r ^ c0_r[ANG_W-1]) ? DELTA_W'(-str_mag) : str_mag;
      S_MUL_Y: if (mul_stat.done)
        ddy_r <= (v_neg_r ^ s0_r[ANG_W-1]) ? DELTA_W'(-str_mag) : str_mag;
      S_MUL_TURN: if (mul_stat.done) a1_r <= {yaw_r, 16'h0} + d32;
      S_ROT1: if (cor_stat.done) begin
        c1_r <= cor_cos;
        s1_r <= cor_sin;
      end
      S_DIV_X: if (div_stat.done)
        ddx_r <= (v_neg_r ^ w_neg_r ^ dsx[ANG_W]) ? DELTA_W'(-arc_mag) : arc_mag;
      S_DIV_Y: if (div_stat.done)
        ddy_r <= (v_neg_r ^ w_neg_r ^ dcy[ANG_W]) ? DELTA_W'(-arc_mag) : arc_mag;
      default: ;
    endcase
  end

  assign in_stall      = state_r != S_IDLE;
  assign out_valid     = out_valid_r;
  assign out_pos_x     = x_r;
  assign out_pos_y     = y_r;
  assign out_heading   = yaw_r;
  assign out_saturated = sat_r;

  // The sequencer never runs two shared units at once.
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cor_stat.busy, mul_stat.busy, div_stat.busy}))
    else $error("more than one shared unit busy");

  // A straight step keeps the heading.
  a_straight_heading: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && upd_go && straight_r) |=> yaw_r == $past(yaw_r))
    else $error("heading changed on a straight step");

  // A saturated word carries a position at one end of its range.
  a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && sat_r) |->
      (x_r == 32'sh7fff_ffff || x_r == 32'sh8000_0000 ||
       y_r == 32'sh7fff_ffff || y_r == 32'sh8000_0000))
    else $error("saturated flag without a clipped position");

endmodule
